### sv/ssd_pkg.sv
// shared constants, segment table and reciprocal constant for the seven-segment serial driver
// no dependencies; compiled first
package ssd_pkg;

  localparam int unsigned DigitCount = 3;
  localparam int unsigned ValueW     = 32;
  localparam int unsigned SegW       = 8;
  localparam int unsigned QuotW      = 29;

  // q / 10 == (q * DivTenMagic) >> DivTenShift for every 32-bit q
  localparam logic [ValueW-1:0] DivTenMagic = 32'hCCCC_CCCD;
  localparam int unsigned       DivTenShift = 35;

  localparam logic [SegW-1:0] BlankHigh = 8'h00;

  function automatic logic [SegW-1:0] seg_pattern(input logic [3:0] digit);
    logic [SegW-1:0] p;
    case (digit)
      4'd0:    p = 8'h3F;
      4'd1:    p = 8'h06;
      4'd2:    p = 8'h5B;
      4'd3:    p = 8'h4F;
      4'd4:    p = 8'h66;
      4'd5:    p = 8'h6D;
      4'd6:    p = 8'h7D;
      4'd7:    p = 8'h07;
      4'd8:    p = 8'h7F;
      4'd9:    p = 8'h6F;
      default: p = BlankHigh;
    endcase
    return p;
  endfunction

endpackage

### sv/ssd_if.sv
// valid/ready channel interfaces: value input, serial bit output, configuration write
// depends on ssd_pkg
interface ssd_in_if;
  logic                       valid;
  logic                       ready;
  logic [ssd_pkg::ValueW-1:0] display_value;
  modport source (output valid, output display_value, input ready);
  modport sink   (input valid, input display_value, output ready);
endinterface

interface ssd_out_if;
  logic valid;
  logic ready;
  logic serial_bit;
  logic latch_after;
  modport source (output valid, output serial_bit, output latch_after, input ready);
  modport sink   (input valid, input serial_bit, input latch_after, output ready);
endinterface

interface ssd_cfg_if;
  logic valid;
  logic ready;
  logic active_low;
  modport source (output valid, output active_low, input ready);
  modport sink   (input valid, input active_low, output ready);
endinterface

### sv/ssd_digit_conv.sv
// decimal digit converter: one divide-by-ten per digit position, builds the frame of segment patterns
// depends on ssd_pkg and ssd_in_if
module ssd_digit_conv #(
  parameter int unsigned DIGIT_COUNT = ssd_pkg::DigitCount,
  localparam int unsigned FrameBits  = ssd_pkg::SegW * DIGIT_COUNT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ssd_in_if.sink               in_i,
  output logic                 frame_valid_o,
  output logic [FrameBits-1:0] frame_o,
  input  logic                 frame_take_i
);
  import ssd_pkg::*;

  localparam int unsigned PosW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [PosW-1:0] LastPos = PosW'(DIGIT_COUNT - 1);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StMul  = 3'b010,
    StDig  = 3'b100
  } conv_state_e;

  conv_state_e       state_q, state_d;
  logic              full_q, full_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [ValueW-1:0] quot_q, quot_d;
  logic [QuotW-1:0]  qd_q, qd_d;
  logic [SegW-1:0]   frame_q [DIGIT_COUNT];

  logic [2*ValueW-1:0] prod;
  logic [3:0]          ten_qd;
  logic [3:0]          digit;
  logic [SegW-1:0]     pattern;
  logic                accept;

  assign in_i.ready = (state_q == StIdle) && !full_q;
  assign accept     = in_i.valid && in_i.ready;

  assign prod    = {{ValueW{1'b0}}, quot_q} * {{ValueW{1'b0}}, DivTenMagic};
  // low nibble of 10 * quotient is enough, the digit is below ten
  assign ten_qd  = {qd_q[0], 3'b000} + {qd_q[2:0], 1'b0};
  assign digit   = quot_q[3:0] - ten_qd;
  assign pattern = ((pos_q != '0) && (quot_q == '0)) ? BlankHigh : seg_pattern(digit);

  always_comb begin
    state_d = state_q;
    full_d  = full_q;
    pos_d   = pos_q;
    quot_d  = quot_q;
    qd_d    = qd_q;
    if (frame_take_i) begin
      full_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (accept) begin
          quot_d  = in_i.display_value;
          pos_d   = '0;
          state_d = StMul;
        end
      end
      StMul: begin
        qd_d    = prod[DivTenShift +: QuotW];
        state_d = StDig;
      end
      StDig: begin
        quot_d = {{(ValueW-QuotW){1'b0}}, qd_q};
        if (pos_q == LastPos) begin
          full_d  = 1'b1;
          state_d = StIdle;
        end else begin
          pos_d   = pos_q + 1'b1;
          state_d = StMul;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      full_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      full_q  <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    quot_q <= quot_d;
    qd_q   <= qd_d;
    if (state_q == StDig) begin
      frame_q[pos_q] <= pattern;
    end
  end

  // units position goes out first, so it sits at the top of the frame
  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      frame_o[FrameBits-1-SegW*i -: SegW] = frame_q[i];
    end
  end

  assign frame_valid_o = full_q;

endmodule

### sv/ssd_shift_out.sv
// frame shifter: emits the frame one bit per output request, flags the last bit for the latch
// depends on ssd_pkg and ssd_out_if
module ssd_shift_out #(
  parameter int unsigned DIGIT_COUNT = ssd_pkg::DigitCount,
  localparam int unsigned FrameBits  = ssd_pkg::SegW * DIGIT_COUNT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 active_low_i,
  input  logic                 frame_valid_i,
  input  logic [FrameBits-1:0] frame_i,
  output logic                 frame_take_o,
  ssd_out_if.source            out_o
);
  import ssd_pkg::*;

  localparam int unsigned CntW = $clog2(FrameBits + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(FrameBits);
  localparam logic [CntW-1:0] CntLast = CntW'(1);

  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [FrameBits-1:0] shift_q, shift_d;
  logic                 fire;

  assign out_o.valid       = (cnt_q != '0);
  assign out_o.serial_bit  = shift_q[FrameBits-1] ^ active_low_i;
  assign out_o.latch_after = (cnt_q == CntLast);
  assign fire              = out_o.valid && out_o.ready;
  assign frame_take_o      = frame_valid_i && ((cnt_q == '0) || (fire && cnt_q == CntLast));

  always_comb begin
    cnt_d   = cnt_q;
    shift_d = shift_q;
    if (frame_take_o) begin
      cnt_d   = CntFull;
      shift_d = frame_i;
    end else if (fire) begin
      cnt_d   = cnt_q - 1'b1;
      shift_d = {shift_q[FrameBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

endmodule

### sv/seven_segment_serial_driver_core.sv
// top level of the seven-segment serial driver: config register, converter and shifter
// depends on ssd_pkg, ssd_if, ssd_digit_conv and ssd_shift_out
//
// Each accepted value produces a frame of 8*DIGIT_COUNT serial bits (24 by default), units
// position first and each pattern MSB first, with latch_after set on the last bit. The output
// shifter moves one bit per output request, so a value occupies 8*DIGIT_COUNT output requests.
// The converter does one multiply-by-reciprocal and one digit step per position; it takes
// a new value only when idle and after the shifter has taken its previous frame. It runs
// while the previous frame is still shifting and holds a finished frame until the last bit
// of the current one is taken, so with values waiting the frames follow each other with no
// gap in the bit stream; output stalls hold the stream. Blanked leading positions are blank
// in the frame and the active_low inversion applies to every bit, blanks included;
// active_low resets to 1 and must only be written while the block is idle.
module seven_segment_serial_driver_core #(
  parameter int unsigned DIGIT_COUNT = ssd_pkg::DigitCount
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssd_in_if.sink    in_i,
  ssd_cfg_if.sink   cfg_i,
  ssd_out_if.source out_o
);
  import ssd_pkg::*;

  localparam int unsigned FrameBits = SegW * DIGIT_COUNT;

  logic                 active_low_q;
  logic                 frame_valid;
  logic                 frame_take;
  logic [FrameBits-1:0] frame;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_low_q <= 1'b1;
    end else if (cfg_i.valid && cfg_i.ready) begin
      active_low_q <= cfg_i.active_low;
    end
  end

  ssd_digit_conv #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_conv (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .frame_valid_o(frame_valid),
    .frame_o      (frame),
    .frame_take_i (frame_take)
  );

  ssd_shift_out #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_shift (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .active_low_i (active_low_q),
    .frame_valid_i(frame_valid),
    .frame_i      (frame),
    .frame_take_o (frame_take),
    .out_o        (out_o)
  );

  a_take_needs_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_take |-> frame_valid)
    else $error("frame taken while none pending");

  a_take_starts_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_take |=> out_o.valid)
    else $error("frame taken but no bit offered");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("converter ready right after a request");

  a_latch_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.latch_after && !frame_valid) |=> !out_o.valid)
    else $error("bits after latch with no frame pending");

endmodule

### dv/ssd_frame_checker.sv
`timescale 1ns / 1ps
// frame checker for the seven-segment serial driver: predicts each 24-bit frame on value accept
// and compares every serial bit request against it; depends on ssd_pkg
module ssd_frame_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [ssd_pkg::ValueW-1:0] display_value_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic                       cfg_anode_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic                       serial_bit_i,
  input  logic                       latch_after_i,
  output int                         fail_count_o,
  output int                         beats_pending_o,
  output int                         values_seen_o,
  output int                         beats_checked_o
);
  import ssd_pkg::*;

  localparam int unsigned FrameBits = SegW * DigitCount;
  localparam int          ReportMax = 10;
  localparam logic [SegW-1:0] DigitGlyph [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  typedef struct packed {
    logic serial_bit;
    logic latch_after;
  } serial_beat_t;

  serial_beat_t expected_beats[$];
  logic         anode_mode;

  function automatic void queue_display_frame(input logic [ValueW-1:0] value);
    logic [ValueW-1:0] quotient;
    logic [SegW-1:0]   glyph;
    int unsigned       beat;
    serial_beat_t      next_beat;
    quotient = value;
    beat     = 0;
    for (int unsigned pos = 0; pos < DigitCount; pos++) begin
      if (pos > 0 && quotient == '0) begin
        glyph = BlankHigh;
      end else begin
        glyph = DigitGlyph[quotient % 10];
      end
      if (anode_mode) begin
        glyph = ~glyph;
      end
      for (int b = SegW - 1; b >= 0; b--) begin
        next_beat.serial_bit  = glyph[b];
        next_beat.latch_after = (beat == FrameBits - 1);
        expected_beats.push_back(next_beat);
        beat++;
      end
      quotient = quotient / 10;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    serial_beat_t seen_beat;
    serial_beat_t want_beat;
    if (!rst_ni) begin
      anode_mode = 1'b1;
      expected_beats.delete();
      fail_count_o    = 0;
      beats_pending_o = 0;
      values_seen_o   = 0;
      beats_checked_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen_beat.serial_bit  = serial_bit_i;
        seen_beat.latch_after = latch_after_i;
        if (expected_beats.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= ReportMax) begin
            $display("%0t: serial bit with no frame pending: bit %b latch %b",
                     $time, seen_beat.serial_bit, seen_beat.latch_after);
          end
        end else begin
          want_beat = expected_beats.pop_front();
          if (seen_beat !== want_beat) begin
            fail_count_o++;
            if (fail_count_o <= ReportMax) begin
              $display("%0t: bit %0d of frame: expected bit %b latch %b, got bit %b latch %b",
                       $time, beats_checked_o % FrameBits, want_beat.serial_bit,
                       want_beat.latch_after, seen_beat.serial_bit, seen_beat.latch_after);
            end
          end
        end
        beats_checked_o++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        anode_mode = cfg_anode_i;
      end
      if (in_valid_i && in_ready_i) begin
        queue_display_frame(display_value_i);
        values_seen_o++;
      end
      beats_pending_o = expected_beats.size();
    end
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// top of the seven-segment serial driver testbench: clock, reset, value and config stimulus,
// serial output stalls and verdict; depends on ssd_pkg, ssd_if, the core and ssd_frame_checker
module testbench;
  import ssd_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int PhaseValues   = 73;

  logic clk_i;
  logic rst_ni;
  logic sender_gaps_on;
  logic sink_stalls_on;
  int   burst_left;
  int   idle_cycles;
  int   cfg_writes;
  int   fail_count;
  int   beats_pending;
  int   values_seen;
  int   beats_checked;

  ssd_in_if  in_if ();
  ssd_cfg_if cfg_if ();
  ssd_out_if out_if ();

  seven_segment_serial_driver_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  ssd_frame_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_if.valid),
    .in_ready_i      (in_if.ready),
    .display_value_i (in_if.display_value),
    .cfg_valid_i     (cfg_if.valid),
    .cfg_ready_i     (cfg_if.ready),
    .cfg_anode_i     (cfg_if.active_low),
    .out_valid_i     (out_if.valid),
    .out_ready_i     (out_if.ready),
    .serial_bit_i    (out_if.serial_bit),
    .latch_after_i   (out_if.latch_after),
    .fail_count_o    (fail_count),
    .beats_pending_o (beats_pending),
    .values_seen_o   (values_seen),
    .beats_checked_o (beats_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // serial side stall pattern, a fresh 16-bit pattern loaded whenever the slot counter wraps
  initial begin
    int unsigned     slot;
    logic [15:0]     stall_pattern;
    slot          = 0;
    stall_pattern = '0;
    out_if.ready  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (slot == 0) begin
        stall_pattern = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom & $urandom);
      end
      out_if.ready <= !(sink_stalls_on && stall_pattern[slot]);
      slot = (slot + 1) % 16;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no request moved for %0d cycles, %0d bits still pending",
                 idle_cycles, beats_pending);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic logic [ValueW-1:0] pick_value();
    logic [ValueW-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = $urandom_range(0, 9);
      1:       v = $urandom_range(0, 99);
      2:       v = $urandom_range(0, 999);
      3:       v = $urandom_range(1000, 99999);
      4:       v = $urandom;
      5:       v = $urandom_range(1, 4294967) * 1000;
      6:       v = $urandom_range(0, 9) * 100 + $urandom_range(0, 9);
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    return v;
  endfunction

  // called and returns at a falling edge; valid stays high within a burst
  task automatic push_value(input logic [ValueW-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = 0;
      if (sender_gaps_on) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 5);
      end
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = sender_gaps_on ? $urandom_range(1, 12) : 1000;
    end
    in_if.valid         <= 1'b1;
    in_if.display_value <= value;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    burst_left--;
  endtask

  task automatic drain_frames();
    in_if.valid <= 1'b0;
    burst_left  = 0;
    while (beats_pending != 0) @(negedge clk_i);
  endtask

  task automatic write_anode(input logic mode);
    cfg_if.valid      <= 1'b1;
    cfg_if.active_low <= mode;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    logic [ValueW-1:0] edge_values [20];
    logic              phase_anode [4];
    edge_values = '{
      32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd101, 32'd999, 32'd1000,
      32'd1005, 32'd123, 32'd456, 32'd789, 32'hFFFF_FFFF, 32'h8000_0000, 32'd1000000,
      32'd7, 32'd8, 32'd20, 32'd305
    };
    phase_anode = '{1'b0, 1'b1, 1'b0, 1'b1};
    rst_ni              = 1'b0;
    sender_gaps_on      = 1'b1;
    sink_stalls_on      = 1'b1;
    burst_left          = 0;
    idle_cycles         = 0;
    cfg_writes          = 0;
    in_if.valid         = 1'b0;
    in_if.display_value = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.active_low   = 1'b1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (edge_values[i]) push_value(edge_values[i]);
    drain_frames();

    for (int phase = 0; phase < 4; phase++) begin
      write_anode(phase_anode[phase]);
      sender_gaps_on = (phase != 1);
      sink_stalls_on = (phase != 1) && (phase != 2);
      for (int n = 0; n < PhaseValues; n++) push_value(pick_value());
      drain_frames();
    end

    repeat (2 * DigitCount + 9) @(posedge clk_i);
    $display("covered %0d values and %0d serial bits over %0d polarity writes",
             values_seen, beats_checked, cfg_writes);
    $display("both polarities, zero, overflow and full-scale values, with and without stalls");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d serial bits mismatched", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/ssd_pkg.sv
sv/ssd_if.sv
sv/ssd_digit_conv.sv
sv/ssd_shift_out.sv
sv/seven_segment_serial_driver_core.sv
dv/ssd_frame_checker.sv
dv/testbench.sv
